// File: sv/multichannel_sensor_scanner_top_assert.svh
// Assertion macros shared by the sensor scanner RTL.
// Included by modules that check their own sequencing; no other dependencies.
`ifndef MULTICHANNEL_SENSOR_SCANNER_TOP_ASSERT_SVH
`define MULTICHANNEL_SENSOR_SCANNER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MSS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define MSS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/mss_pkg.sv
// Shared widths, constants and register index codes of the sensor scanner.
// No dependencies; imported by the interfaces and every module.
package mss_pkg;

   localparam int CHANNELS    = 8;
   localparam int CH_W        = 3;
   localparam int CNT_W       = 4;
   localparam int WINDOW      = 5;
   localparam int WIN_DEPTH   = CHANNELS * WINDOW;
   localparam int WIN_AW      = 6;
   localparam int HEAD_W      = 3;
   localparam int LEVEL_W     = 8;
   localparam int SUM_W       = 11;
   localparam int RAW_W       = 12;
   localparam int TIME_W      = 32;
   localparam int DEB_W       = 16;
   localparam int TOL_W       = 64;
   localparam int MASK_W      = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;

   // Square root unit: 36-bit radicand, one root bit per step
   localparam int RAD_W       = 36;
   localparam int ROOT_W      = 18;
   localparam int REM_W       = 20;
   localparam int STEP_W      = 5;

   // Shared multiplier operands and product
   localparam int MUL_A_W     = 24;
   localparam int MUL_B_W     = 22;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;

   // Scaling to 0..255: m = floor((FULL_SCALE - x) * 255 / FULL_SCALE)
   // FULL_SCALE = 32 * 8189, so divide by 32 (shift) then by 8189 (reciprocal)
   localparam logic [ROOT_W-1:0]  FULL_SCALE  = 18'd262048;
   localparam logic [LEVEL_W-1:0] TOP_LEVEL   = 8'd255;
   localparam int                 Q_LSB       = 5;
   localparam int                 Q_W         = 21;
   localparam logic [Q_W-1:0]     SCALE_DIV   = 21'd8189;
   localparam logic [MUL_B_W-1:0] SCALE_RECIP = 22'd2097920;
   localparam int                 SCALE_SHIFT = 34;

   // Divide by five: floor(s / 5) = (s * 52429) >> 18 for s below 2048
   localparam logic [15:0]        FIFTH_RECIP = 16'd52429;
   localparam int                 FIFTH_SHIFT = 18;

   // Reset values of the control registers
   localparam logic [CNT_W-1:0]   COUNT_RST    = 4'd8;
   localparam logic [DEB_W-1:0]   DEBOUNCE_RST = 16'd50;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHANNEL_COUNT = 2'd0,
      CSR_BUTTON_MASK   = 2'd1,
      CSR_DEBOUNCE      = 2'd2,
      CSR_TOLERANCE     = 2'd3
   } csr_index_type;

endpackage

// File: sv/mss_req_if.sv
// Scan step channel: valid/ready handshake with time and raw readings.
// Depends on mss_pkg for field widths.
interface mss_req_if import mss_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [TIME_W-1:0]   now_ms;
   logic [RAW_W-1:0]    analog_raw;
   logic                pin_level;

   modport source (output valid, now_ms, analog_raw, pin_level, input ready);
   modport sink   (input valid, now_ms, analog_raw, pin_level, output ready);
endinterface

// File: sv/mss_rsp_if.sv
// Change report channel: valid/ready handshake with channel and new level.
// Depends on mss_pkg for field widths.
interface mss_rsp_if import mss_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CH_W-1:0]     channel;
   logic                is_button;
   logic [LEVEL_W-1:0]  level;

   modport source (output valid, channel, is_button, level, input ready);
   modport sink   (input valid, channel, is_button, level, output ready);
endinterface

// File: sv/mss_isqrt.sv
// Bit-serial integer square root: one root bit per cycle for the 18-bit root.
// Depends on mss_pkg for widths.
module mss_isqrt import mss_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAD_W-1:0]  radicand,
   output logic              busy,
   output logic [ROOT_W-1:0] root
);

   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [STEP_W-1:0] step_ff;

   logic [REM_W+1:0]  trial_rem;
   logic [REM_W+1:0]  trial_sub;
   logic              take;

   // Bring down the next two radicand bits and test root*4+1 against them
   always_comb begin
      trial_rem = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial_sub = {2'b00, root_ff, 2'b01};
      take      = (trial_rem >= trial_sub);
   end

   // Load on start, then one digit step per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (start) begin
         step_ff <= STEP_W'(ROOT_W);
      end else if (step_ff != '0) begin
         step_ff <= step_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (step_ff != '0) begin
         rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
         if (take) begin
            rem_ff  <= REM_W'(trial_rem - trial_sub);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= trial_rem[REM_W-1:0];
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign busy = (step_ff != '0);
   assign root = root_ff;

endmodule

// File: sv/multichannel_sensor_scanner_top.sv
// Round-robin scanner over eight sensor channels (buttons or linearized analog inputs with a
// five-sample moving average); one report item at most per scan step item. The block takes
// one step item at a time. A step too soon after the channel's last check and a button
// check without a change return to S_IDLE; a reporting button check goes to S_EMIT. An
// analog check runs S_SQR to S_FIX, then S_AVG, S_CMP and S_EMIT if it reports, or S_FILL
// and S_EMIT on a first visit. Its path rests on the bit-serial square root of the cubed
// reading (18 digit steps) and on the one shared 24x22 multiplier, which serves the cube,
// the scaling to 0..255 and the average in turn. A finished report waits in an output
// register, so the next step item is taken while it is pending; a further report holds the
// sequencer until the receiver takes the first. Depends on mss_pkg, mss_req_if, mss_rsp_if,
// mss_isqrt and the assertion macro header.
`include "multichannel_sensor_scanner_top_assert.svh"

module multichannel_sensor_scanner_top import mss_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mss_req_if.sink               req_chan,
   mss_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_SQR, S_CUBE, S_ROOT_GO, S_ROOT, S_SCALE,
      S_RECIP, S_EST, S_FIX, S_FILL, S_AVG, S_CMP, S_EMIT
   } state_type;

   // Control registers
   logic [CNT_W-1:0]   channel_count_ff;
   logic [MASK_W-1:0]  button_mask_ff;
   logic [DEB_W-1:0]   debounce_ff;
   logic [TOL_W-1:0]   tol_pack_ff;

   // Per-channel state
   logic [CH_W-1:0]    scan_ptr_ff;
   logic [TIME_W-1:0]  last_check_ff [CHANNELS];
   logic [LEVEL_W-1:0] stored_level_ff [CHANNELS];
   logic               seen_ff [CHANNELS];
   logic [HEAD_W-1:0]  head_ff [CHANNELS];
   logic [SUM_W-1:0]   sum_ff [CHANNELS];

   // Sample window memory
   logic [LEVEL_W-1:0] win_mem [WIN_DEPTH];
   logic [LEVEL_W-1:0] win_rdata_ff;
   logic               win_we;
   logic [WIN_AW-1:0]  win_waddr;
   logic [LEVEL_W-1:0] win_wdata;

   // Item in flight
   state_type          state_ff;
   logic [CH_W-1:0]    ch_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [RAW_W-1:0]   raw_ff;
   logic               pin_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [Q_W-1:0]     q_ff;
   logic [LEVEL_W-1:0] est_ff;
   logic [LEVEL_W-1:0] value_ff;
   logic [SUM_W-1:0]   new_sum_ff;
   logic [HEAD_W-1:0]  fill_cnt_ff;
   logic [LEVEL_W-1:0] res_level_ff;

   // Output register
   logic               rsp_valid_ff;
   logic [CH_W-1:0]    rsp_channel_ff;
   logic               rsp_button_ff;
   logic [LEVEL_W-1:0] rsp_level_ff;

   // Combinational helpers
   logic [CNT_W-1:0]   eff_count;
   logic [CNT_W-1:0]   ptr_inc;
   logic [CH_W-1:0]    next_ptr;
   logic [TIME_W-1:0]  elapsed;
   logic               too_soon;
   logic               is_btn;
   logic [LEVEL_W-1:0] btn_val;
   logic [LEVEL_W-1:0] tol;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [Q_W-1:0]     fix_rem;
   logic [LEVEL_W-1:0] fix_m;
   logic [LEVEL_W-1:0] fix_value;
   logic [WIN_AW-1:0]  win_base;
   logic [WIN_AW-1:0]  rd_addr;
   logic [WIN_AW-1:0]  fill_addr;
   logic [SUM_W-1:0]   new_sum;
   logic [SUM_W-1:0]   fill_sum;
   logic [HEAD_W-1:0]  head_next;
   logic [LEVEL_W-1:0] avg;
   logic [LEVEL_W-1:0] avg_diff;
   logic               emit_free;
   logic               root_busy;
   logic [ROOT_W-1:0]  root;
   logic               req_fire;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= COUNT_RST;
         button_mask_ff   <= '0;
         debounce_ff      <= DEBOUNCE_RST;
         tol_pack_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[CNT_W-1:0];
            CSR_BUTTON_MASK:   button_mask_ff   <= csr_wdata[MASK_W-1:0];
            CSR_DEBOUNCE:      debounce_ff      <= csr_wdata[DEB_W-1:0];
            CSR_TOLERANCE:     tol_pack_ff      <= csr_wdata[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance the scan pointer and wrap at the effective channel count
   always_comb begin
      eff_count = (channel_count_ff > CNT_W'(CHANNELS)) ? CNT_W'(CHANNELS) : channel_count_ff;
      ptr_inc   = {1'b0, scan_ptr_ff} + CNT_W'(1);
      if (ptr_inc >= eff_count || ptr_inc >= CNT_W'(CHANNELS)) begin
         next_ptr = '0;
      end else begin
         next_ptr = ptr_inc[CH_W-1:0];
      end
   end

   // Debounce test and channel kind
   always_comb begin
      elapsed  = now_ff - last_check_ff[ch_ff];
      too_soon = (elapsed <= {{(TIME_W-DEB_W){1'b0}}, debounce_ff});
      is_btn   = button_mask_ff[ch_ff];
      btn_val  = {{(LEVEL_W-1){1'b0}}, ~pin_ff};
      tol      = tol_pack_ff[{ch_ff, 3'b000} +: LEVEL_W];
   end

   // Operand select of the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQR: begin
            mul_a = MUL_A_W'(raw_ff);
            mul_b = MUL_B_W'(raw_ff);
         end
         S_CUBE: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = MUL_B_W'(raw_ff);
         end
         S_SCALE: begin
            mul_a = MUL_A_W'(FULL_SCALE - root);
            mul_b = MUL_B_W'(TOP_LEVEL);
         end
         S_RECIP: begin
            mul_a = MUL_A_W'(prod_ff[Q_LSB +: Q_W]);
            mul_b = SCALE_RECIP;
         end
         S_EST: begin
            mul_a = MUL_A_W'(prod_ff[SCALE_SHIFT +: LEVEL_W]);
            mul_b = MUL_B_W'(SCALE_DIV);
         end
         S_AVG: begin
            mul_a = MUL_A_W'(new_sum_ff);
            mul_b = MUL_B_W'(FIFTH_RECIP);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // Correct the reciprocal estimate and finish the window arithmetic
   always_comb begin
      fix_rem   = q_ff - prod_ff[Q_W-1:0];
      fix_m     = est_ff + LEVEL_W'(fix_rem >= SCALE_DIV);
      fix_value = TOP_LEVEL - fix_m;
      win_base  = {1'b0, ch_ff, 2'b00} + {3'b000, ch_ff};
      rd_addr   = win_base + WIN_AW'(head_ff[ch_ff]);
      fill_addr = win_base + WIN_AW'(fill_cnt_ff);
      new_sum   = sum_ff[ch_ff] - SUM_W'(win_rdata_ff) + SUM_W'(fix_value);
      fill_sum  = SUM_W'({value_ff, 2'b00}) + SUM_W'(value_ff);
      head_next = (head_ff[ch_ff] == HEAD_W'(WINDOW - 1)) ? '0
                                                         : head_ff[ch_ff] + HEAD_W'(1);
      avg       = prod_ff[FIFTH_SHIFT +: LEVEL_W];
      avg_diff  = (avg > stored_level_ff[ch_ff]) ? avg - stored_level_ff[ch_ff]
                                                 : stored_level_ff[ch_ff] - avg;
   end

   // Window write port: replace the oldest sample, or fill on a first visit
   always_comb begin
      win_we    = 1'b0;
      win_waddr = rd_addr;
      win_wdata = fix_value;
      if (state_ff == S_FIX && seen_ff[ch_ff]) begin
         win_we = 1'b1;
      end else if (state_ff == S_FILL) begin
         win_we    = 1'b1;
         win_waddr = fill_addr;
         win_wdata = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[win_waddr] <= win_wdata;
      end
      win_rdata_ff <= win_mem[rd_addr];
   end

   mss_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_ROOT_GO),
      .radicand (prod_ff[RAD_W-1:0]),
      .busy     (root_busy),
      .root     (root)
   );

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign emit_free = !rsp_valid_ff || rsp_chan.ready;

   // Sequencer, per-channel state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_ptr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            last_check_ff[i]   <= '0;
            stored_level_ff[i] <= '0;
            seen_ff[i]         <= 1'b0;
            head_ff[i]         <= '0;
         end
      end else begin
         // Drop a taken report unless the next one replaces it in this cycle
         if (rsp_valid_ff && rsp_chan.ready && state_ff != S_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  scan_ptr_ff <= next_ptr;
                  ch_ff       <= next_ptr;
                  now_ff      <= req_chan.now_ms;
                  raw_ff      <= req_chan.analog_raw;
                  pin_ff      <= req_chan.pin_level;
                  state_ff    <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (too_soon) begin
                  state_ff <= S_IDLE;
               end else begin
                  last_check_ff[ch_ff] <= now_ff;
                  if (!is_btn) begin
                     state_ff <= S_SQR;
                  end else if (btn_val != stored_level_ff[ch_ff]) begin
                     stored_level_ff[ch_ff] <= btn_val;
                     seen_ff[ch_ff]         <= 1'b1;
                     res_level_ff           <= btn_val;
                     state_ff               <= S_EMIT;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_SQR:     state_ff <= S_CUBE;
            S_CUBE:    state_ff <= S_ROOT_GO;
            S_ROOT_GO: state_ff <= S_ROOT;
            S_ROOT: begin
               if (!root_busy) begin
                  state_ff <= S_SCALE;
               end
            end
            S_SCALE:   state_ff <= S_RECIP;
            S_RECIP: begin
               q_ff     <= prod_ff[Q_LSB +: Q_W];
               state_ff <= S_EST;
            end
            S_EST: begin
               est_ff   <= prod_ff[SCALE_SHIFT +: LEVEL_W];
               state_ff <= S_FIX;
            end
            S_FIX: begin
               if (seen_ff[ch_ff]) begin
                  sum_ff[ch_ff]  <= new_sum;
                  new_sum_ff     <= new_sum;
                  head_ff[ch_ff] <= head_next;
                  state_ff       <= S_AVG;
               end else begin
                  value_ff               <= fix_value;
                  fill_cnt_ff            <= '0;
                  seen_ff[ch_ff]         <= 1'b1;
                  stored_level_ff[ch_ff] <= fix_value;
                  res_level_ff           <= fix_value;
                  state_ff               <= S_FILL;
               end
            end
            S_FILL: begin
               fill_cnt_ff <= fill_cnt_ff + HEAD_W'(1);
               if (fill_cnt_ff == HEAD_W'(WINDOW - 1)) begin
                  sum_ff[ch_ff]  <= fill_sum;
                  head_ff[ch_ff] <= '0;
                  state_ff       <= S_EMIT;
               end
            end
            S_AVG:     state_ff <= S_CMP;
            S_CMP: begin
               if (avg_diff > tol) begin
                  stored_level_ff[ch_ff] <= avg;
                  res_level_ff           <= avg;
                  state_ff               <= S_EMIT;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_EMIT: begin
               if (emit_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_channel_ff <= ch_ff;
                  rsp_button_ff  <= is_btn;
                  rsp_level_ff   <= res_level_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default:   state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_chan.ready     = (state_ff == S_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.channel   = rsp_channel_ff;
   assign rsp_chan.is_button = rsp_button_ff;
   assign rsp_chan.level     = rsp_level_ff;

   // Checks on sequencing and datapath ranges
   `MSS_ASSERT_NEXT(a_accept_starts_check, req_fire, state_ff == S_CHECK, "accepted item did not start a check")
   `MSS_ASSERT_NEXT(a_channel_in_range, req_fire, (ch_ff == '0 || {1'b0, ch_ff} < channel_count_ff), "scan pointer beyond channel count")
   `MSS_ASSERT_NOW(a_root_in_range, state_ff == S_SCALE, root <= FULL_SCALE, "square root above full scale")
   `MSS_ASSERT_NOW(a_button_level, rsp_valid_ff && rsp_button_ff, rsp_level_ff[LEVEL_W-1:1] == '0, "button report above one")
   `MSS_ASSERT_NOW(a_emit_matches_store, state_ff == S_EMIT, stored_level_ff[ch_ff] == res_level_ff, "report differs from stored level")

endmodule
